### rtl/core/hmp_to_midi_track_transcoder_core_defines.svh
// assertion helpers for the transcoder checker
// both expect clk and arst_n in the scope where they are used
`ifndef HMP_TO_MIDI_TRACK_TRANSCODER_CORE_DEFINES_SVH
`define HMP_TO_MIDI_TRACK_TRANSCODER_CORE_DEFINES_SVH

// same-cycle implication
`define HMP2MIDI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HMP2MIDI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/hmp2midi_pkg.sv
`timescale 1ns / 1ps

package hmp2midi_pkg;

	typedef enum logic [2:0] {
		PH_DELTA  = 3'd0,
		PH_STATUS = 3'd1,
		PH_CHAN   = 3'd2,
		PH_MTYPE  = 3'd3,
		PH_MLEN   = 3'd4,
		PH_MBODY  = 3'd5,
		PH_DONE   = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		ERR_NONE       = 2'd0,
		ERR_NO_STATUS  = 2'd1,
		ERR_DELTA_LONG = 2'd2,
		ERR_BAD_STATUS = 2'd3
	} err_code_t;

	// status and meta bytes
	localparam logic [7:0] META_STATUS = 8'hFF;
	localparam logic [7:0] META_END    = 8'h2F;

	// channel message kinds (status high nibble)
	localparam logic [3:0] ST_NOTE_OFF = 4'h8;
	localparam logic [3:0] ST_NOTE_ON  = 4'h9;
	localparam logic [3:0] ST_POLY_AT  = 4'hA;
	localparam logic [3:0] ST_CTRL     = 4'hB;
	localparam logic [3:0] ST_PROG     = 4'hC;
	localparam logic [3:0] ST_CHAN_AT  = 4'hD;
	localparam logic [3:0] ST_PITCH    = 4'hE;

	localparam int QUEUE_DEPTH = 4;

	// per-run flags that ride on the last result of a run
	typedef struct packed {
		logic        done;
		err_code_t   err;
		logic [31:0] length;
	} run_info_t;

endpackage

### rtl/core/hmp2midi_in_if.sv
`timescale 1ns / 1ps

interface hmp2midi_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       first_of_track;
	logic       last_of_data;

	modport source (output valid, output in_byte, output first_of_track,
		output last_of_data, input ready);
	modport sink (input valid, input in_byte, input first_of_track,
		input last_of_data, output ready);
endinterface

### rtl/core/hmp2midi_out_if.sv
`timescale 1ns / 1ps

interface hmp2midi_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic        has_byte;
	logic        last_of_run;
	logic        track_done;
	logic [31:0] track_length;
	logic [1:0]  error_code;

	modport source (output valid, output out_byte, output has_byte, output last_of_run,
		output track_done, output track_length, output error_code, input ready);
	modport sink (input valid, input out_byte, input has_byte, input last_of_run,
		input track_done, input track_length, input error_code, output ready);
endinterface

### rtl/core/hmp_to_midi_track_transcoder_core.sv
`timescale 1ns / 1ps
// flow: an accepted item's run is written into the run queue, then its first result is loaded
//   into the output register; the rest of its results follow one per cycle unless ready is low
// throughput: one item per cycle while the run queue has room; each gives up to MAX_DELTA_BYTES
//   results; the four-entry queue between parser and output stage absorbs bursts of long deltas
// reset: arst_n clears parser phase, running status, counts, the run queue and the output valid

module hmp_to_midi_track_transcoder_core import hmp2midi_pkg::*; #(
	parameter int MAX_DELTA_BYTES = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	hmp2midi_in_if.sink    hmp,
	hmp2midi_out_if.source midi
);

	localparam int NB_W = $clog2(MAX_DELTA_BYTES + 1);
	localparam int QW   = NB_W + MAX_DELTA_BYTES * 8 + $bits(run_info_t);

	// at most one run per accepted item: its bytes, how many, and the end-of-run flags
	logic                             push, pop, q_full, q_empty;
	logic [NB_W-1:0]                  f_nb, h_nb;
	logic [MAX_DELTA_BYTES-1:0][7:0]  f_bytes, h_bytes;
	run_info_t                        f_info, h_info;
	logic [QW-1:0]                    q_wdata, q_rdata;

	// front: parses HMP bytes, rewrites deltas, strips running status
	hmp2midi_front #(
		.MAX_DELTA_BYTES(MAX_DELTA_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.hmp      (hmp),
		.q_full   (q_full),
		.push     (push),
		.run_nb   (f_nb),
		.run_bytes(f_bytes),
		.run_info (f_info)
	);

	assign q_wdata = {f_nb, f_bytes, f_info};

	// run queue decouples parser stalls from output stalls
	hmp2midi_queue #(
		.W(QW)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (q_wdata),
		.full  (q_full),
		.pop   (pop),
		.empty (q_empty),
		.rdata (q_rdata)
	);

	assign {h_nb, h_bytes, h_info} = q_rdata;

	// back: serializes each run into result items, flags on the last one
	hmp2midi_back #(
		.MAX_DELTA_BYTES(MAX_DELTA_BYTES)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_empty(q_empty),
		.h_nb   (h_nb),
		.h_bytes(h_bytes),
		.h_info (h_info),
		.pop    (pop),
		.midi   (midi)
	);

endmodule

### rtl/core/hmp2midi_front.sv
`timescale 1ns / 1ps

module hmp2midi_front import hmp2midi_pkg::*; #(
	parameter int MAX_DELTA_BYTES = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	hmp2midi_in_if.sink                         hmp,
	input  logic                                q_full,
	output logic                                push,
	output logic [$clog2(MAX_DELTA_BYTES+1)-1:0] run_nb,
	output logic [MAX_DELTA_BYTES-1:0][7:0]     run_bytes,
	output run_info_t                           run_info
);

	localparam int DC_W = $clog2(MAX_DELTA_BYTES);
	localparam int NB_W = $clog2(MAX_DELTA_BYTES + 1);
	localparam int SH_N = MAX_DELTA_BYTES - 1;

	phase_t      phase_q;
	logic [DC_W-1:0] dc_q;
	logic [7:0]  rs_q;
	logic [7:0]  bl_q;
	logic        me_q;
	logic [31:0] cnt_q;
	logic        failed_q;
	logic [SH_N-1:0][6:0] sh_q;

	phase_t      eff_phase, nxt_phase;
	logic [DC_W-1:0] eff_dc, nxt_dc;
	logic [7:0]  eff_rs, nxt_rs;
	logic [7:0]  eff_bl, nxt_bl, bl_tmp;
	logic        eff_me, nxt_me;
	logic [31:0] eff_cnt, nxt_cnt;
	logic        eff_failed, nxt_failed;
	logic        skip, shift_en, done_ev, done, emit, accept, ok;
	logic [NB_W-1:0] nb;
	err_code_t   err;
	logic [7:0]  b;

	assign b          = hmp.in_byte;
	assign hmp.ready  = !q_full;
	assign accept     = hmp.valid && hmp.ready;

	// start of track clears state before the byte is looked at
	assign eff_phase  = hmp.first_of_track ? PH_DELTA : phase_q;
	assign eff_dc     = hmp.first_of_track ? '0 : dc_q;
	assign eff_rs     = hmp.first_of_track ? '0 : rs_q;
	assign eff_bl     = hmp.first_of_track ? '0 : bl_q;
	assign eff_me     = hmp.first_of_track ? 1'b0 : me_q;
	assign eff_cnt    = hmp.first_of_track ? '0 : cnt_q;
	assign eff_failed = hmp.first_of_track ? 1'b0 : failed_q;
	assign skip       = eff_failed || (eff_phase == PH_DONE);

	always_comb begin
		nxt_phase  = eff_phase;
		nxt_dc     = eff_dc;
		nxt_rs     = eff_rs;
		nxt_bl     = eff_bl;
		nxt_me     = eff_me;
		nxt_cnt    = eff_cnt;
		nxt_failed = eff_failed;
		nb         = '0;
		err        = ERR_NONE;
		done_ev    = 1'b0;
		done       = 1'b0;
		shift_en   = 1'b0;
		ok         = 1'b1;
		bl_tmp     = '0;
		run_bytes  = '0;
		run_bytes[0] = b;
		if (!skip) begin
			case (eff_phase)
				PH_DELTA: begin
					if (b[7]) begin
						// final group first, then stored groups newest to oldest
						run_bytes[0] = {eff_dc != '0, b[6:0]};
						for (int k = 1; k < MAX_DELTA_BYTES; k++) begin
							run_bytes[k] = {NB_W'(k) < NB_W'(eff_dc), sh_q[k-1]};
						end
						nb        = NB_W'(eff_dc) + NB_W'(1);
						nxt_dc    = '0;
						nxt_phase = PH_STATUS;
					end else if (eff_dc >= DC_W'(MAX_DELTA_BYTES - 1)) begin
						err = ERR_DELTA_LONG;
					end else begin
						shift_en = 1'b1;
						nxt_dc   = eff_dc + DC_W'(1);
					end
				end
				PH_STATUS: begin
					if (b == META_STATUS) begin
						nb        = NB_W'(1);
						nxt_phase = PH_MTYPE;
					end else if (!b[7]) begin
						err = ERR_NO_STATUS;
					end else begin
						case (b[7:4])
							ST_NOTE_OFF, ST_NOTE_ON, ST_POLY_AT, ST_CTRL, ST_PITCH: begin
								nxt_bl = 8'd2;
							end
							ST_PROG, ST_CHAN_AT: begin
								nxt_bl = 8'd1;
							end
							default: begin
								ok  = 1'b0;
								err = ERR_BAD_STATUS;
							end
						endcase
						if (ok) begin
							// running status: drop a repeated status
							nb        = (b != eff_rs) ? NB_W'(1) : NB_W'(0);
							nxt_rs    = b;
							nxt_phase = PH_CHAN;
						end
					end
				end
				PH_CHAN: begin
					nb     = NB_W'(1);
					bl_tmp = (eff_bl != '0) ? eff_bl - 8'd1 : 8'd0;
					nxt_bl = bl_tmp;
					if (bl_tmp == '0) begin
						nxt_phase = PH_DELTA;
					end
				end
				PH_MTYPE: begin
					nb        = NB_W'(1);
					nxt_me    = (b == META_END);
					nxt_phase = PH_MLEN;
				end
				PH_MLEN, PH_MBODY: begin
					nb = NB_W'(1);
					if (eff_phase == PH_MLEN) begin
						bl_tmp = b;
					end else begin
						bl_tmp = (eff_bl != '0) ? eff_bl - 8'd1 : 8'd0;
					end
					nxt_bl = bl_tmp;
					if (bl_tmp == '0) begin
						if (eff_me) begin
							done_ev = 1'b1;
						end else begin
							nxt_phase = PH_DELTA;
						end
					end else begin
						nxt_phase = PH_MBODY;
					end
				end
				default: begin
					nxt_phase = PH_DELTA;
				end
			endcase
			nxt_cnt = eff_cnt + 32'(nb);
			if (err != ERR_NONE) begin
				nxt_failed = 1'b1;
			end else if (done_ev || hmp.last_of_data) begin
				done      = 1'b1;
				nxt_phase = PH_DONE;
			end
		end
	end

	assign emit = !skip && ((nb != '0) || (err != ERR_NONE) || done);
	assign push = accept && emit;
	assign run_nb = nb;
	assign run_info.done   = done;
	assign run_info.err    = err;
	assign run_info.length = done ? nxt_cnt : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_DELTA;
			dc_q     <= '0;
			rs_q     <= '0;
			bl_q     <= '0;
			me_q     <= 1'b0;
			cnt_q    <= '0;
			failed_q <= 1'b0;
		end else if (accept) begin
			phase_q  <= nxt_phase;
			dc_q     <= nxt_dc;
			rs_q     <= nxt_rs;
			bl_q     <= nxt_bl;
			me_q     <= nxt_me;
			cnt_q    <= nxt_cnt;
			failed_q <= nxt_failed;
		end
	end

	// delta groups, newest at index 0
	always_ff @(posedge clk) begin
		if (accept && shift_en) begin
			sh_q[0] <= b[6:0];
			for (int k = 1; k < SH_N; k++) begin
				sh_q[k] <= sh_q[k-1];
			end
		end
	end

endmodule

### rtl/core/hmp2midi_queue.sv
`timescale 1ns / 1ps

module hmp2midi_queue import hmp2midi_pkg::*; #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic         empty,
	output logic [W-1:0] rdata
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [W-1:0]  slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= wdata;
		end
	end

endmodule

### rtl/core/hmp2midi_back.sv
`timescale 1ns / 1ps

module hmp2midi_back import hmp2midi_pkg::*; #(
	parameter int MAX_DELTA_BYTES = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 q_empty,
	input  logic [$clog2(MAX_DELTA_BYTES+1)-1:0] h_nb,
	input  logic [MAX_DELTA_BYTES-1:0][7:0]      h_bytes,
	input  run_info_t                            h_info,
	output logic                                 pop,
	hmp2midi_out_if.source                       midi
);

	localparam int IX_W = $clog2(MAX_DELTA_BYTES);
	localparam int NB_W = $clog2(MAX_DELTA_BYTES + 1);

	logic [IX_W-1:0] idx_q;
	logic            vld_q, has_q, last_q, done_q;
	logic [7:0]      byte_q;
	logic [31:0]     len_q;
	logic [1:0]      err_q;
	logic            load, fin;

	// last result of the head run: a run with no bytes gives one flag-only result
	assign fin  = (h_nb == '0) || (NB_W'(idx_q) == h_nb - NB_W'(1));
	assign load = !q_empty && (!vld_q || midi.ready);
	assign pop  = load && fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (load) begin
				vld_q <= 1'b1;
				idx_q <= fin ? '0 : idx_q + IX_W'(1);
			end else if (midi.ready) begin
				vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			has_q  <= (h_nb != '0);
			byte_q <= (h_nb != '0) ? h_bytes[idx_q] : 8'd0;
			last_q <= fin;
			done_q <= fin && h_info.done;
			len_q  <= (fin && h_info.done) ? h_info.length : 32'd0;
			err_q  <= fin ? h_info.err : ERR_NONE;
		end
	end

	assign midi.valid        = vld_q;
	assign midi.out_byte     = byte_q;
	assign midi.has_byte     = has_q;
	assign midi.last_of_run  = last_q;
	assign midi.track_done   = done_q;
	assign midi.track_length = len_q;
	assign midi.error_code   = err_q;

endmodule

### rtl/core/hmp2midi_checker.sv
`timescale 1ns / 1ps
`include "hmp_to_midi_track_transcoder_core_defines.svh"

module hmp2midi_checker import hmp2midi_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        valid,
	input logic        ready,
	input logic [7:0]  out_byte,
	input logic        has_byte,
	input logic        last_of_run,
	input logic        track_done,
	input logic [31:0] track_length,
	input logic [1:0]  error_code
);

	logic [8:0] held;
	logic       stalled, err_free, flags_clear, byteless_ok;

	assign held        = {out_byte, last_of_run};
	assign stalled     = valid && !ready;
	assign err_free    = (error_code == ERR_NONE);
	assign flags_clear = !track_done && err_free && (track_length == '0);
	assign byteless_ok = last_of_run && (out_byte == '0) && (track_done || !err_free);

	`HMP2MIDI_ASSERT_NEXT(a_hold, stalled, valid && $stable(held), "stalled item changed")
	`HMP2MIDI_ASSERT_NOW(a_mid_clean, valid && !last_of_run, flags_clear, "flags on a non-final item")
	`HMP2MIDI_ASSERT_NOW(a_empty_reason, valid && !has_byte, byteless_ok, "byteless item without event")
	`HMP2MIDI_ASSERT_NOW(a_done_no_err, valid && track_done, err_free, "track done with error")

endmodule

bind hmp_to_midi_track_transcoder_core hmp2midi_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.valid       (midi.valid),
	.ready       (midi.ready),
	.out_byte    (midi.out_byte),
	.has_byte    (midi.has_byte),
	.last_of_run (midi.last_of_run),
	.track_done  (midi.track_done),
	.track_length(midi.track_length),
	.error_code  (midi.error_code)
);
